@@ sv/fsn_pkg.sv @@
package fsn_pkg;

   // Widths of the fixed datapath.
   localparam int EDGE_W  = 17;   // b - a and c - a
   localparam int PROD_W  = 34;   // edge by edge product
   localparam int NORM_W  = 35;   // normal component
   localparam int SUM_W   = 36;   // n.x + n.y
   localparam int MAG_W   = 34;   // magnitude of a normal component
   localparam int SMAG_W  = 35;   // positive facing term
   localparam int SQ_W    = 68;   // square of a component magnitude
   localparam int LEN_W   = 70;   // squared normal length and facing square
   localparam int CMP_W   = 90;   // running terms of the level search
   localparam int LVL_W   = 8;    // lit level
   localparam int STEPS   = 8;    // one search step per level bit
   localparam int RHS_SH  = 15;   // 2 * 128 * 128 = 32768

   localparam logic [LVL_W-1:0] MAX_LIT    = 8'd204;
   localparam logic [8:0]       GRID_LEVEL = 9'd256;

   typedef struct packed {
      logic signed [15:0] a_x;
      logic signed [15:0] a_y;
      logic signed [15:0] a_z;
      logic signed [15:0] b_x;
      logic signed [15:0] b_y;
      logic signed [15:0] b_z;
      logic signed [15:0] c_x;
      logic signed [15:0] c_y;
      logic signed [15:0] c_z;
      logic               grid_face;
   } req_type;

   typedef struct packed {
      logic [8:0] intensity;
      logic       degenerate;
   } rsp_type;

endpackage

@@ sv/face_normal_flat_shading_unit.sv @@
// Channel   | Ports                      | Direction | Handshake
// request   | start, busy, req_data      | in        | beat taken when start and not busy
// response  | rsp_valid, rsp_data        | out       | one-cycle strobe, cannot be held off
//
// One triangle enters every cycle; busy never rises.
// Pipeline stages in order: edges, products, normal, facing term, squares, length,
// eight level search steps (one per result bit) and the output register.
// Reset clears only the valid bits that travel with each beat.
// The receiver cannot stall, so the pipeline never holds.
module face_normal_flat_shading_unit
   import fsn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // Stage 1: edge vectors.
   logic                     v1_ff, g1_ff;
   logic signed [EDGE_W-1:0] e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      g1_ff  <= req_data.grid_face;
      e1x_ff <= EDGE_W'(req_data.b_x) - EDGE_W'(req_data.a_x);
      e1y_ff <= EDGE_W'(req_data.b_y) - EDGE_W'(req_data.a_y);
      e1z_ff <= EDGE_W'(req_data.b_z) - EDGE_W'(req_data.a_z);
      e2x_ff <= EDGE_W'(req_data.c_x) - EDGE_W'(req_data.a_x);
      e2y_ff <= EDGE_W'(req_data.c_y) - EDGE_W'(req_data.a_y);
      e2z_ff <= EDGE_W'(req_data.c_z) - EDGE_W'(req_data.a_z);
   end

   // Stage 2: the six cross product terms.
   logic                     v2_ff, g2_ff;
   logic signed [PROD_W-1:0] pxa_ff, pxb_ff, pya_ff, pyb_ff, pza_ff, pzb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      g2_ff  <= g1_ff;
      pxa_ff <= e1y_ff * e2z_ff;
      pxb_ff <= e1z_ff * e2y_ff;
      pya_ff <= e1z_ff * e2x_ff;
      pyb_ff <= e1x_ff * e2z_ff;
      pza_ff <= e1x_ff * e2y_ff;
      pzb_ff <= e1y_ff * e2x_ff;
   end

   // Stage 3: the normal.
   logic                     v3_ff, g3_ff;
   logic signed [NORM_W-1:0] nx_ff, ny_ff, nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      g3_ff <= g2_ff;
      nx_ff <= NORM_W'(pxa_ff) - NORM_W'(pxb_ff);
      ny_ff <= NORM_W'(pya_ff) - NORM_W'(pyb_ff);
      nz_ff <= NORM_W'(pza_ff) - NORM_W'(pzb_ff);
   end

   // Stage 4: magnitudes, zero test and the facing term s = -(n.x + n.y).
   logic signed [SUM_W-1:0]  s_in;
   logic signed [NORM_W-1:0] nxa_in, nya_in, nza_in;
   logic                     v4_ff, g4_ff, z4_ff;
   logic [MAG_W-1:0]         ux_ff, uy_ff, uz_ff;
   logic [SMAG_W-1:0]        sm_ff;

   always_comb begin
      s_in   = -(SUM_W'(nx_ff) + SUM_W'(ny_ff));
      nxa_in = nx_ff[NORM_W-1] ? -nx_ff : nx_ff;
      nya_in = ny_ff[NORM_W-1] ? -ny_ff : ny_ff;
      nza_in = nz_ff[NORM_W-1] ? -nz_ff : nz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      g4_ff <= g3_ff;
      z4_ff <= (nx_ff == '0) && (ny_ff == '0) && (nz_ff == '0);
      ux_ff <= nxa_in[MAG_W-1:0];
      uy_ff <= nya_in[MAG_W-1:0];
      uz_ff <= nza_in[MAG_W-1:0];
      // A face turned away gets a zero bound, so the search settles on zero.
      sm_ff <= (s_in > 0) ? s_in[SMAG_W-1:0] : '0;
   end

   // Stage 5: squares.
   logic              v5_ff, g5_ff, z5_ff;
   logic [SQ_W-1:0]   qx_ff, qy_ff, qz_ff;
   logic [LEN_W-1:0]  ss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      g5_ff <= g4_ff;
      z5_ff <= z4_ff;
      qx_ff <= ux_ff * ux_ff;
      qy_ff <= uy_ff * uy_ff;
      qz_ff <= uz_ff * uz_ff;
      ss_ff <= sm_ff * sm_ff;
   end

   // Stage 6: squared length M and bound R = 32768 * s * s; search starts at zero.
   logic             sv_ff [0:STEPS];
   logic             sg_ff [0:STEPS];
   logic             sz_ff [0:STEPS];
   logic [CMP_W-1:0] sq_ff [0:STEPS];
   logic [CMP_W-1:0] sp_ff [0:STEPS];
   logic [CMP_W-1:0] sm2_ff [0:STEPS];
   logic [CMP_W-1:0] sr_ff [0:STEPS];
   logic [LVL_W-1:0] sk_ff [0:STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else begin
         sv_ff[0] <= v5_ff;
      end
      sg_ff[0]  <= g5_ff;
      sz_ff[0]  <= z5_ff;
      sq_ff[0]  <= '0;
      sp_ff[0]  <= '0;
      sm2_ff[0] <= CMP_W'(qx_ff) + CMP_W'(qy_ff) + CMP_W'(qz_ff);
      sr_ff[0]  <= CMP_W'(ss_ff) << RHS_SH;
      sk_ff[0]  <= '0;
   end

   // Level search, one bit a stage from the top. With P = k*M and Q = k*k*M,
   // trying t = k + 2^b gives Q + P*2^(b+1) + M*4^b, so only shifts and adds.
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam int B = STEPS - 1 - i;
      logic [CMP_W-1:0] qt_in;
      logic [LVL_W-1:0] t_in;
      logic             take_in;

      always_comb begin
         t_in    = sk_ff[i] | (LVL_W'(1) << B);
         qt_in   = sq_ff[i] + (sp_ff[i] << (B + 1)) + (sm2_ff[i] << (2 * B));
         take_in = (t_in <= MAX_LIT) && (qt_in <= sr_ff[i]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[i+1] <= 1'b0;
         end else begin
            sv_ff[i+1] <= sv_ff[i];
         end
         sg_ff[i+1]  <= sg_ff[i];
         sz_ff[i+1]  <= sz_ff[i];
         sm2_ff[i+1] <= sm2_ff[i];
         sr_ff[i+1]  <= sr_ff[i];
         if (take_in) begin
            sq_ff[i+1] <= qt_in;
            sp_ff[i+1] <= sp_ff[i] + (sm2_ff[i] << B);
            sk_ff[i+1] <= t_in;
         end else begin
            sq_ff[i+1] <= sq_ff[i];
            sp_ff[i+1] <= sp_ff[i];
            sk_ff[i+1] <= sk_ff[i];
         end
      end
   end

   // Output register: grid faces and degenerate normals override the level.
   logic    ov_ff;
   rsp_type od_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= sv_ff[STEPS];
      end
      if (sg_ff[STEPS]) begin
         od_ff.intensity  <= GRID_LEVEL;
         od_ff.degenerate <= 1'b0;
      end else if (sz_ff[STEPS]) begin
         od_ff.intensity  <= '0;
         od_ff.degenerate <= 1'b1;
      end else begin
         od_ff.intensity  <= 9'(sk_ff[STEPS]);
         od_ff.degenerate <= 1'b0;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = od_ff;

endmodule

@@ tb/sv/face_normal_flat_shading_unit_tb.sv @@
`timescale 1ns / 100ps

module face_normal_flat_shading_unit_tb;
   import fsn_pkg::*;

   // One triangle waiting to be sent, with the sender's idle odds for it.
   typedef struct {
      req_type tri_data;
      int      idle_pct;
      bit      drain_first;
   } tri_beat_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   tri_beat_type pending_tris[$];
   rsp_type   expected_shades[$];
   bit        took;
   int        mismatch_count;
   int        beats_sent;
   int        shades_seen;
   int        idle_cycles;
   int        grid_sent;
   int        degen_seen;
   int        saturated_seen;
   bit        timed_out;

   face_normal_flat_shading_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Clock with a 12 ns period.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Predicts the shade of one triangle from exact integer geometry.
   function automatic rsp_type shade_of(req_type t);
      longint      e1x, e1y, e1z, e2x, e2y, e2z;
      longint      nx, ny, nz, facing;
      logic [127:0] len_sq, facing_sq, trial;
      int unsigned lvl, cand, bitv;
      rsp_type     r;
      e1x = longint'(t.b_x) - longint'(t.a_x);
      e1y = longint'(t.b_y) - longint'(t.a_y);
      e1z = longint'(t.b_z) - longint'(t.a_z);
      e2x = longint'(t.c_x) - longint'(t.a_x);
      e2y = longint'(t.c_y) - longint'(t.a_y);
      e2z = longint'(t.c_z) - longint'(t.a_z);
      nx = e1y * e2z - e1z * e2y;
      ny = e1z * e2x - e1x * e2z;
      nz = e1x * e2y - e1y * e2x;
      r.intensity  = '0;
      r.degenerate = 1'b0;
      if (t.grid_face) begin
         r.intensity = GRID_LEVEL;
      end else if (nx == 0 && ny == 0 && nz == 0) begin
         r.degenerate = 1'b1;
      end else begin
         facing = -(nx + ny);
         if (facing > 0) begin
            if (nx < 0) nx = -nx;
            if (ny < 0) ny = -ny;
            if (nz < 0) nz = -nz;
            len_sq = 128'(nx) * 128'(nx) + 128'(ny) * 128'(ny) + 128'(nz) * 128'(nz);
            facing_sq = (128'(facing) * 128'(facing)) << RHS_SH;
            lvl = 0;
            // Binary search for the largest level whose squared cosine still fits.
            for (bitv = 128; bitv != 0; bitv = bitv >> 1) begin
               cand = lvl | bitv;
               trial = 128'(cand * cand) * len_sq;
               if (cand <= MAX_LIT && trial <= facing_sq) lvl = cand;
            end
            r.intensity = 9'(lvl);
         end
      end
      return r;
   endfunction

   function automatic req_type make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz, bit grid);
      req_type t;
      t.a_x = 16'(ax); t.a_y = 16'(ay); t.a_z = 16'(az);
      t.b_x = 16'(bx); t.b_y = 16'(by); t.b_z = 16'(bz);
      t.c_x = 16'(cx); t.c_y = 16'(cy); t.c_z = 16'(cz);
      t.grid_face = grid;
      return t;
   endfunction

   task automatic queue_tri(req_type t, int idle_pct, bit drain_first);
      tri_beat_type b;
      b.tri_data    = t;
      b.idle_pct    = idle_pct;
      b.drain_first = drain_first;
      pending_tris = {pending_tris, b};
   endtask

   // Random triangle: full-range noise, random faces within +/-600 or +/-8000, or collinear ones.
   function automatic req_type random_tri();
      req_type      t;
      logic [159:0] raw;
      int           pick, ax, ay, az, dx, dy, dz, m;
      pick = $urandom_range(99);
      if (pick < 40) begin
         raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
         t = raw[$bits(req_type)-1:0];
      end else if (pick < 90) begin
         m = ($urandom_range(3) == 0) ? 8000 : 600;
         t = make_tri($urandom_range(2 * m) - m, $urandom_range(2 * m) - m,
                      $urandom_range(2 * m) - m, $urandom_range(2 * m) - m,
                      $urandom_range(2 * m) - m, $urandom_range(2 * m) - m,
                      $urandom_range(2 * m) - m, $urandom_range(2 * m) - m,
                      $urandom_range(2 * m) - m, 1'b0);
      end else begin
         ax = $urandom_range(2000) - 1000;
         ay = $urandom_range(2000) - 1000;
         az = $urandom_range(2000) - 1000;
         dx = $urandom_range(200) - 100;
         dy = $urandom_range(200) - 100;
         dz = $urandom_range(200) - 100;
         m  = $urandom_range(5) - 2;
         t = make_tri(ax, ay, az, ax + dx, ay + dy, az + dz,
                      ax + m * dx, ay + m * dy, az + m * dz, 1'b0);
      end
      t.grid_face = ($urandom_range(7) == 0);
      return t;
   endfunction

   // Response side: predict on each accepted beat, check each strobed result.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         took <= 1'b0;
         idle_cycles <= 0;
      end else begin
         took <= start && !busy;
         if (start && !busy) begin
            expected_shades = {expected_shades, shade_of(req_data)};
            beats_sent <= beats_sent + 1;
            if (req_data.grid_face) grid_sent <= grid_sent + 1;
         end
         if (rsp_valid) begin
            shades_seen <= shades_seen + 1;
            if (rsp_data.degenerate) degen_seen <= degen_seen + 1;
            if (rsp_data.intensity == 9'(MAX_LIT)) saturated_seen <= saturated_seen + 1;
            if (expected_shades.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("ERROR: unexpected result intensity=%0d degenerate=%0b",
                           rsp_data.intensity, rsp_data.degenerate);
            end else begin
               want = expected_shades.pop_front();
               if (want.intensity !== rsp_data.intensity
                   || want.degenerate !== rsp_data.degenerate) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("ERROR: intensity exp %0d got %0d, degenerate exp %0b got %0b",
                              want.intensity, rsp_data.intensity,
                              want.degenerate, rsp_data.degenerate);
               end
            end
         end
         // Watchdog on cycles where no beat moves in either direction.
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Request side: drive the next triangle at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (took && pending_tris.size() > 0) void'(pending_tris.pop_front());
         if (pending_tris.size() == 0) begin
            start <= 1'b0;
         end else if (pending_tris[0].drain_first && expected_shades.size() != 0) begin
            start <= 1'b0;
         end else begin
            pending_tris[0].drain_first = 1'b0;
            if ($urandom_range(99) < pending_tris[0].idle_pct) begin
               start <= 1'b0;
            end else begin
               start    <= 1'b1;
               req_data <= pending_tris[0].tri_data;
            end
         end
      end
   end

   initial begin
      int idle_plan[4];
      int n;
      idle_plan = '{0, 64, 0, 28};
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      mismatch_count = 0;
      beats_sent = 0;
      shades_seen = 0;
      grid_sent = 0;
      degen_seen = 0;
      saturated_seen = 0;
      timed_out = 1'b0;

      // Directed faces: extremes, grid, zero-length normal, turned away, saturated.
      queue_tri(make_tri(0, 0, 0, 1, -1, 0, 0, 0, 1, 1'b0), 0, 1'b0);
      queue_tri(make_tri(0, 0, 0, 0, 0, 1, 1, -1, 0, 1'b0), 0, 1'b0);
      queue_tri(make_tri(0, 0, 0, 1, -1, 0, 0, 0, 1, 1'b1), 0, 1'b0);
      queue_tri(make_tri(5, 5, 5, 5, 5, 5, 5, 5, 5, 1'b0), 0, 1'b0);
      queue_tri(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2, 1'b0), 0, 1'b0);
      queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0), 0, 1'b0);
      queue_tri(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1, 1'b0), 0, 1'b0);
      queue_tri(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0, 1'b0), 0, 1'b0);
      queue_tri(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                         -32768, 32767, 32767, 1'b0), 0, 1'b0);
      queue_tri(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                         32767, -32768, -32768, 1'b0), 0, 1'b0);
      queue_tri(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                         -32768, -32768, -32768, 1'b0), 0, 1'b0);
      queue_tri(make_tri(32767, -32768, 32767, -32768, 32767, -32768,
                         32767, 32767, 32767, 1'b0), 0, 1'b0);
      queue_tri(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, 1'b0), 0, 1'b0);
      queue_tri(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b1), 0, 1'b0);
      queue_tri(make_tri(0, 0, 0, 100, -90, 10, 0, 0, 100, 1'b0), 0, 1'b0);
      queue_tri(make_tri(0, 0, 0, 100, -20, 30, 0, 0, 100, 1'b0), 0, 1'b0);
      queue_tri(make_tri(0, 0, 0, 256, -256, 0, 0, 0, 256, 1'b0), 0, 1'b0);

      // Random faces in four sender phases, each after a full drain.
      for (int ph = 0; ph < 4; ph++) begin
         for (int i = 0; i < 335; i++) begin
            n = ($urandom_range(9) == 0) ? 90 : idle_plan[ph];
            queue_tri(random_tri(), n, (i == 0));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while ((pending_tris.size() != 0 || expected_shades.size() != 0) && !timed_out) begin
         @(posedge clock);
         if (idle_cycles > 3000) timed_out = 1'b1;
      end
      repeat (30) @(posedge clock);

      if (timed_out) begin
         $display("TEST FAILED");
      end else begin
         $display("Sent %0d triangles (%0d grid), checked %0d shades.",
                  beats_sent, grid_sent, shades_seen);
         $display("Zero-length normals: %0d, saturated shades: %0d, mismatches: %0d.",
                  degen_seen, saturated_seen, mismatch_count);
         if (mismatch_count == 0 && expected_shades.size() == 0)
            $display("TEST PASSED");
         else
            $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ face_normal_flat_shading_unit.f @@
sv/fsn_pkg.sv
sv/face_normal_flat_shading_unit.sv
tb/sv/face_normal_flat_shading_unit_tb.sv
